@@ rtl/setb_pkg.sv @@
// Package for the sorted expiry timer bank: field widths, action codes,
// queue sizing and the operation struct passed from front end to engine.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package setb_pkg;

    localparam int ACT_W   = 3;
    localparam int ID_W    = 3;
    localparam int VALUE_W = 31;
    localparam int ORDER_W = 16;

    localparam int NUM_TIMERS_DEF = 8;
    localparam int TICK_WIDTH_DEF = 32;

    localparam int MAX_RESULTS = 8;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [ACT_W-1:0] ACT_TICK       = 3'd0;
    localparam logic [ACT_W-1:0] ACT_SETUP      = 3'd1;
    localparam logic [ACT_W-1:0] ACT_START      = 3'd2;
    localparam logic [ACT_W-1:0] ACT_STOP       = 3'd3;
    localparam logic [ACT_W-1:0] ACT_SET_PERIOD = 3'd4;
    localparam logic [ACT_W-1:0] ACT_READ       = 3'd5;
    localparam logic [ACT_W-1:0] ACT_SET_MODE   = 3'd6;

    localparam logic STATUS_OK       = 1'b0;
    localparam logic STATUS_INACTIVE = 1'b1;

    typedef struct packed {
        logic               is_tick;
        logic               id_ok;
        logic [ACT_W-1:0]   action;
        logic [ID_W-1:0]    timer_id;
        logic [VALUE_W-1:0] value;
        logic               periodic;
    } setb_op_t;

endpackage

`default_nettype wire

@@ rtl/setb_if.sv @@
// Valid/ready channel interfaces for the timer bank: request and response.
// Depends on setb_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface setb_req_if;
    import setb_pkg::*;

    logic               valid;
    logic               ready;
    logic [ACT_W-1:0]   action;
    logic [ID_W-1:0]    timer_id;
    logic [VALUE_W-1:0] value;
    logic               periodic;

    modport source (output valid, output action, output timer_id, output value,
                    output periodic, input ready);
    modport sink (input valid, input action, input timer_id, input value,
                  input periodic, output ready);
endinterface

interface setb_rsp_if;
    import setb_pkg::*;

    logic               valid;
    logic               ready;
    logic [ID_W-1:0]    slot;
    logic               expired;
    logic               status;
    logic [VALUE_W-1:0] read_value;
    logic               last;

    modport source (output valid, output slot, output expired, output status,
                    output read_value, output last, input ready);
    modport sink (input valid, input slot, input expired, input status,
                  input read_value, input last, output ready);
endinterface

`default_nettype wire

@@ rtl/setb_front.sv @@
// Front end: accepts request beats, classifies them and holds them in a
// short queue for the engine. Depends on setb_pkg and setb_if.
`timescale 1ns / 1ps
`default_nettype none

module setb_front #(
    parameter int NUM_TIMERS = setb_pkg::NUM_TIMERS_DEF
) (
    input  wire                 clk,
    input  wire                 rst_n,
    setb_req_if.sink            req,
    output logic                op_valid,
    input  wire                 op_ready,
    output setb_pkg::setb_op_t  op
);
    import setb_pkg::*;

    setb_op_t          q_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    setb_op_t          in_op;
    logic              push;
    logic              pop;

    always_comb
    begin
        in_op.is_tick  = (req.action == ACT_TICK);
        in_op.id_ok    = (32'(req.timer_id) < NUM_TIMERS);
        in_op.action   = req.action;
        in_op.timer_id = req.timer_id;
        in_op.value    = (req.value == '0) ? VALUE_W'(1) : req.value;
        in_op.periodic = req.periodic;
    end

    assign req.ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign push      = req.valid && req.ready;
    assign op_valid  = (count_reg != '0);
    assign pop       = op_valid && op_ready;
    assign op        = q_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= in_op;
        end
    end

endmodule

`default_nettype wire

@@ rtl/setb_engine.sv @@
// Engine: timer state, command execution, and the expiry pick loop
// (key capture, compare tree, commit) with the response register.
// Depends on setb_pkg and setb_if.
`timescale 1ns / 1ps
`default_nettype none

module setb_engine #(
    parameter int NUM_TIMERS = setb_pkg::NUM_TIMERS_DEF,
    parameter int TICK_WIDTH = setb_pkg::TICK_WIDTH_DEF
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 op_valid,
    output logic                op_ready,
    input  setb_pkg::setb_op_t  op,
    setb_rsp_if.source          rsp
);
    import setb_pkg::*;

    localparam int IDX_W  = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int LEAF_N = 1 << IDX_W;
    localparam int NODE_N = 2 * LEAF_N - 1;
    localparam int KEY_W  = 1 + TICK_WIDTH + ORDER_W;
    localparam logic [TICK_WIDTH-1:0] TICK_HALF = {1'b0, {(TICK_WIDTH - 1){1'b1}}};

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_KEY  = 4'b0010,
        ST_SEL  = 4'b0100,
        ST_FIN  = 4'b1000
    } state_t;

    state_t                state_reg;
    state_t                state_next;

    logic [TICK_WIDTH-1:0] tick_reg;
    logic [TICK_WIDTH-1:0] tick_next;
    logic [ORDER_W-1:0]    order_reg;
    logic [ORDER_W-1:0]    order_next;
    logic [CNT_W-1:0]      n_reg;
    logic [CNT_W-1:0]      n_next;
    logic                  pend_v_reg;
    logic                  pend_v_next;
    logic [IDX_W-1:0]      pend_idx_reg;
    logic [IDX_W-1:0]      pend_idx_next;

    logic [TICK_WIDTH-1:0] deadline_reg [NUM_TIMERS];
    logic [VALUE_W-1:0]    period_reg   [NUM_TIMERS];
    logic [ORDER_W-1:0]    start_reg    [NUM_TIMERS];
    logic [NUM_TIMERS-1:0] mode_reg;
    logic [NUM_TIMERS-1:0] active_reg;
    logic [NUM_TIMERS-1:0] done_reg;
    logic [KEY_W-1:0]      key_reg      [NUM_TIMERS];
    logic [KEY_W-1:0]      lane_key     [NUM_TIMERS];

    logic [KEY_W-1:0]      node_key [NODE_N];
    logic [IDX_W-1:0]      node_idx [NODE_N];

    logic                  rsp_valid_reg;
    logic [ID_W-1:0]       rsp_slot_reg;
    logic                  rsp_expired_reg;
    logic                  rsp_status_reg;
    logic [VALUE_W-1:0]    rsp_read_reg;
    logic                  rsp_last_reg;

    logic                  space;
    logic                  emit;
    logic [ID_W-1:0]       e_slot;
    logic                  e_expired;
    logic                  e_status;
    logic [VALUE_W-1:0]    e_read;
    logic                  e_last;
    logic                  cmd_fire;
    logic                  tick_start;
    logic                  commit;
    logic                  found;
    logic [IDX_W-1:0]      best;
    logic [IDX_W-1:0]      id_idx;
    logic                  rearm;

    assign id_idx = IDX_W'(op.timer_id);
    assign found  = node_key[0][KEY_W-1];
    assign best   = node_idx[0];
    assign space  = !rsp_valid_reg || rsp.ready;
    assign rearm  = commit && mode_reg[best];

    // per-timer sort key: due flag, age past deadline, start age
    always_comb
    begin
        logic [TICK_WIDTH-1:0] age;
        logic [ORDER_W-1:0]    ord;
        for (int i = 0; i < NUM_TIMERS; i++)
        begin
            age = tick_reg - deadline_reg[i];
            ord = order_reg - start_reg[i];
            if (active_reg[i] && !done_reg[i] && (age < TICK_HALF))
            begin
                lane_key[i] = {1'b1, age, ord};
            end
            else
            begin
                lane_key[i] = '0;
            end
        end
    end

    // compare tree; ties keep the lower slot
    genvar g;
    generate
        for (g = 0; g < LEAF_N; g++)
        begin : g_leaf
            if (g < NUM_TIMERS)
            begin : g_used
                assign node_key[LEAF_N - 1 + g] = key_reg[g];
            end
            else
            begin : g_pad
                assign node_key[LEAF_N - 1 + g] = '0;
            end
            assign node_idx[LEAF_N - 1 + g] = IDX_W'(g);
        end
        for (g = 0; g < LEAF_N - 1; g++)
        begin : g_node
            assign node_key[g] = (node_key[2 * g + 2] > node_key[2 * g + 1]) ?
                                 node_key[2 * g + 2] : node_key[2 * g + 1];
            assign node_idx[g] = (node_key[2 * g + 2] > node_key[2 * g + 1]) ?
                                 node_idx[2 * g + 2] : node_idx[2 * g + 1];
        end
    endgenerate

    always_comb
    begin
        state_next    = state_reg;
        tick_next     = tick_reg;
        n_next        = n_reg;
        pend_v_next   = pend_v_reg;
        pend_idx_next = pend_idx_reg;
        op_ready      = 1'b0;
        emit          = 1'b0;
        e_slot        = '0;
        e_expired     = 1'b0;
        e_status      = STATUS_OK;
        e_read        = '0;
        e_last        = 1'b1;
        cmd_fire      = 1'b0;
        tick_start    = 1'b0;
        commit        = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (op_valid && op.is_tick)
                begin
                    op_ready    = 1'b1;
                    tick_start  = 1'b1;
                    tick_next   = tick_reg + TICK_WIDTH'(1);
                    n_next      = '0;
                    pend_v_next = 1'b0;
                    state_next  = ST_KEY;
                end
                else if (op_valid && space)
                begin
                    op_ready = 1'b1;
                    emit     = 1'b1;
                    cmd_fire = op.id_ok;
                    e_slot   = op.timer_id;
                    if (op.action == ACT_STOP && op.id_ok && !active_reg[id_idx])
                    begin
                        e_status = STATUS_INACTIVE;
                    end
                    if (op.action == ACT_READ && op.id_ok)
                    begin
                        e_read = period_reg[id_idx];
                    end
                end
            end
            ST_KEY:
            begin
                state_next = ST_SEL;
            end
            ST_SEL:
            begin
                if (!found)
                begin
                    state_next = ST_FIN;
                end
                else if (!pend_v_reg || space)
                begin
                    commit        = 1'b1;
                    emit          = pend_v_reg;
                    e_slot        = ID_W'(pend_idx_reg);
                    e_expired     = 1'b1;
                    e_last        = 1'b0;
                    pend_v_next   = 1'b1;
                    pend_idx_next = best;
                    n_next        = n_reg + CNT_W'(1);
                    state_next    = (n_reg == CNT_W'(MAX_RESULTS - 1)) ? ST_FIN : ST_KEY;
                end
            end
            ST_FIN:
            begin
                if (space)
                begin
                    emit       = 1'b1;
                    e_slot     = pend_v_reg ? ID_W'(pend_idx_reg) : '0;
                    e_expired  = pend_v_reg;
                    e_last     = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        order_next = order_reg;
        if ((cmd_fire && op.action == ACT_START) || rearm)
        begin
            order_next = order_reg + ORDER_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            tick_reg     <= '0;
            order_reg    <= '0;
            n_reg        <= '0;
            pend_v_reg   <= 1'b0;
            pend_idx_reg <= '0;
            mode_reg     <= '0;
            active_reg   <= '0;
            done_reg     <= '0;
            for (int i = 0; i < NUM_TIMERS; i++)
            begin
                period_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg    <= state_next;
            tick_reg     <= tick_next;
            order_reg    <= order_next;
            n_reg        <= n_next;
            pend_v_reg   <= pend_v_next;
            pend_idx_reg <= pend_idx_next;
            if (tick_start)
            begin
                done_reg <= '0;
            end
            for (int i = 0; i < NUM_TIMERS; i++)
            begin
                if (cmd_fire && id_idx == IDX_W'(i))
                begin
                    case (op.action)
                        ACT_SETUP:
                        begin
                            period_reg[i] <= op.value;
                            mode_reg[i]   <= op.periodic;
                            active_reg[i] <= 1'b0;
                        end
                        ACT_START:      active_reg[i] <= 1'b1;
                        ACT_STOP:       active_reg[i] <= 1'b0;
                        ACT_SET_PERIOD: period_reg[i] <= op.value;
                        ACT_SET_MODE:   mode_reg[i]   <= op.periodic;
                        default:        ;
                    endcase
                end
                if (commit && best == IDX_W'(i))
                begin
                    done_reg[i]   <= 1'b1;
                    active_reg[i] <= mode_reg[i];
                end
            end
        end
    end

    // deadline, start order and sort keys carry no reset
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < NUM_TIMERS; i++)
        begin
            if (cmd_fire && id_idx == IDX_W'(i) && op.action == ACT_SETUP)
            begin
                deadline_reg[i] <= '0;
            end
            else if ((cmd_fire && id_idx == IDX_W'(i) && op.action == ACT_START) ||
                     (rearm && best == IDX_W'(i)))
            begin
                deadline_reg[i] <= tick_reg + TICK_WIDTH'(period_reg[i]);
                start_reg[i]    <= order_reg;
            end
            if (state_reg == ST_KEY)
            begin
                key_reg[i] <= lane_key[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (emit)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            rsp_slot_reg    <= e_slot;
            rsp_expired_reg <= e_expired;
            rsp_status_reg  <= e_status;
            rsp_read_reg    <= e_read;
            rsp_last_reg    <= e_last;
        end
    end

    assign rsp.valid      = rsp_valid_reg;
    assign rsp.slot       = rsp_slot_reg;
    assign rsp.expired    = rsp_expired_reg;
    assign rsp.status     = rsp_status_reg;
    assign rsp.read_value = rsp_read_reg;
    assign rsp.last       = rsp_last_reg;

endmodule

`default_nettype wire

@@ rtl/sorted_expiry_timer_bank.sv @@
// Sorted expiry timer bank. Non-tick actions: executed in the engine on accept, result registered
// and shown in the cycle after accept; one action per cycle while the response side keeps up.
// Tick with n due timers: the tick is accepted, then each expiry takes a key capture plus a
// compare-tree pick and commit; a final empty pick (skipped after eight expiries) and the last
// beat close the tick. Response stalls hold the pick loop and the last beat.
// Reset (rst_n, async, active low) clears counters, modes, periods, active flags, queue, rsp.
`timescale 1ns / 1ps
`default_nettype none

module sorted_expiry_timer_bank #(
    parameter int NUM_TIMERS = setb_pkg::NUM_TIMERS_DEF,
    parameter int TICK_WIDTH = setb_pkg::TICK_WIDTH_DEF
) (
    input  wire        clk,
    input  wire        rst_n,
    setb_req_if.sink   req,
    setb_rsp_if.source rsp
);
    import setb_pkg::*;

    logic     op_valid;
    logic     op_ready;
    setb_op_t op;

    setb_front #(
        .NUM_TIMERS (NUM_TIMERS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req),
        .op_valid (op_valid),
        .op_ready (op_ready),
        .op       (op)
    );

    setb_engine #(
        .NUM_TIMERS (NUM_TIMERS),
        .TICK_WIDTH (TICK_WIDTH)
    ) u_engine (
        .clk      (clk),
        .rst_n    (rst_n),
        .op_valid (op_valid),
        .op_ready (op_ready),
        .op       (op),
        .rsp      (rsp)
    );

endmodule

`default_nettype wire

@@ sim/sorted_expiry_timer_bank_tb.sv @@
// Self-checking testbench for sorted_expiry_timer_bank: random-gap request driver,
// response monitor, and a timer-bank predictor that orders expiries on every tick.
// Depends on setb_pkg, setb_if.sv and the RTL top level.
`timescale 1ns / 1ps

module sorted_expiry_timer_bank_tb;
    import setb_pkg::*;

    localparam int NUM_TIMERS = NUM_TIMERS_DEF;
    localparam int TICK_W = TICK_WIDTH_DEF;
    localparam logic [TICK_W-1:0] TICK_HALF = {1'b0, {(TICK_W-1){1'b1}}};
    localparam logic [ACT_W-1:0] ACT_UNUSED = 3'd7;
    localparam int RANDOM_ITEMS = 135;
    localparam int STALL_LIMIT = 4000;
    localparam int HOLD_CYCLES = 250;
    localparam int TAIL_CYCLES = 40;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic [ACT_W-1:0]   action;
        logic [ID_W-1:0]    timer_id;
        logic [VALUE_W-1:0] value;
        logic               periodic;
    } timer_cmd_t;

    typedef struct packed {
        logic [ID_W-1:0]    slot;
        logic               expired;
        logic               status;
        logic [VALUE_W-1:0] read_value;
        logic               last;
    } timer_rsp_t;

    logic clk;
    logic rst_n;

    setb_req_if req_ch ();
    setb_rsp_if rsp_ch ();

    sorted_expiry_timer_bank i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    timer_cmd_t pending_cmds[$];
    timer_rsp_t results_due[$];

    // predicted timer bank state
    logic [TICK_W-1:0]     tick_now;
    logic [ORDER_W-1:0]    order_next;
    logic [TICK_W-1:0]     due_at[NUM_TIMERS];
    logic [VALUE_W-1:0]    period_of[NUM_TIMERS];
    logic [ORDER_W-1:0]    start_seq[NUM_TIMERS];
    logic [NUM_TIMERS-1:0] running;
    logic [NUM_TIMERS-1:0] periodic_on;

    timer_cmd_t taken_cmd;
    timer_cmd_t next_cmd;
    timer_rsp_t want;
    int tx_gap;
    int tx_calm;
    int sent_beats;
    int rx_stall;
    int rx_calm;
    int mismatches;
    int idle_cycles;
    int holds_done;
    int hold_left;
    logic hold_on;
    logic timed_out;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #4 clk = ~clk;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic add_cmd(input logic [ACT_W-1:0] act, input int id,
                           input logic [VALUE_W-1:0] val, input logic per);
        timer_cmd_t c;
        c.action = act;
        c.timer_id = ID_W'(id);
        c.value = val;
        c.periodic = per;
        pending_cmds.push_back(c);
    endtask

    task automatic arm_timer(input int t);
        due_at[t] = tick_now + TICK_W'(period_of[t]);
        start_seq[t] = order_next;
        order_next = order_next + ORDER_W'(1);
        running[t] = 1'b1;
    endtask

    task automatic predict_timer_results(input timer_cmd_t c);
        logic [VALUE_W-1:0]    per_val;
        logic [TICK_W-1:0]     age;
        logic [TICK_W-1:0]     best_age;
        logic [ORDER_W-1:0]    ord;
        logic [ORDER_W-1:0]    best_ord;
        logic [NUM_TIMERS-1:0] reported;
        logic                  status;
        logic [VALUE_W-1:0]    rd;
        int best;
        int n;
        int hits[MAX_RESULTS];
        if (c.action == ACT_TICK)
        begin
            tick_now = tick_now + TICK_W'(1);
            reported = '0;
            n = 0;
            while (n < MAX_RESULTS)
            begin
                best = -1;
                best_age = '0;
                best_ord = '0;
                for (int i = 0; i < NUM_TIMERS; i++)
                begin
                    age = tick_now - due_at[i];
                    ord = order_next - start_seq[i];
                    if (running[i] && !reported[i] && age < TICK_HALF &&
                        (best < 0 || age > best_age ||
                         (age == best_age && ord > best_ord)))
                    begin
                        best = i;
                        best_age = age;
                        best_ord = ord;
                    end
                end
                if (best < 0)
                    break;
                reported[best] = 1'b1;
                if (periodic_on[best])
                    arm_timer(best);
                else
                    running[best] = 1'b0;
                hits[n] = best;
                n++;
            end
            if (n == 0)
                results_due.push_back({ID_W'(0), 1'b0, STATUS_OK, VALUE_W'(0), 1'b1});
            for (int k = 0; k < n; k++)
                results_due.push_back({ID_W'(hits[k]), 1'b1, STATUS_OK, VALUE_W'(0),
                                       k == n - 1});
        end
        else
        begin
            per_val = (c.value == '0) ? VALUE_W'(1) : c.value;
            status = STATUS_OK;
            rd = '0;
            case (c.action)
                ACT_SETUP:
                begin
                    period_of[c.timer_id] = per_val;
                    periodic_on[c.timer_id] = c.periodic;
                    running[c.timer_id] = 1'b0;
                    due_at[c.timer_id] = '0;
                end
                ACT_START:
                    arm_timer(int'(c.timer_id));
                ACT_STOP:
                begin
                    if (running[c.timer_id])
                        running[c.timer_id] = 1'b0;
                    else
                        status = STATUS_INACTIVE;
                end
                ACT_SET_PERIOD:
                    period_of[c.timer_id] = per_val;
                ACT_READ:
                    rd = period_of[c.timer_id];
                ACT_SET_MODE:
                    periodic_on[c.timer_id] = c.periodic;
                default:
                    ;
            endcase
            results_due.push_back({c.timer_id, 1'b0, status, rd, 1'b1});
        end
    endtask

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_ch.valid <= 1'b0;
            req_ch.action <= ACT_TICK;
            req_ch.timer_id <= '0;
            req_ch.value <= '0;
            req_ch.periodic <= 1'b0;
            tx_gap <= 0;
            tx_calm <= 0;
            sent_beats <= 0;
            tick_now = '0;
            order_next = '0;
            running = '0;
            periodic_on = '0;
            for (int i = 0; i < NUM_TIMERS; i++)
            begin
                due_at[i] = '0;
                period_of[i] = '0;
                start_seq[i] = '0;
            end
        end
        else
        begin
            if (req_ch.valid && req_ch.ready)
            begin
                taken_cmd.action = req_ch.action;
                taken_cmd.timer_id = req_ch.timer_id;
                taken_cmd.value = req_ch.value;
                taken_cmd.periodic = req_ch.periodic;
                predict_timer_results(taken_cmd);
                sent_beats <= sent_beats + 1;
            end
            if (!req_ch.valid || req_ch.ready)
            begin
                if (tx_gap > 0)
                begin
                    req_ch.valid <= 1'b0;
                    tx_gap <= tx_gap - 1;
                end
                else if (pending_cmds.size() > 0)
                begin
                    next_cmd = pending_cmds.pop_front();
                    req_ch.valid <= 1'b1;
                    req_ch.action <= next_cmd.action;
                    req_ch.timer_id <= next_cmd.timer_id;
                    req_ch.value <= next_cmd.value;
                    req_ch.periodic <= next_cmd.periodic;
                    if (tx_calm > 0)
                        tx_calm <= tx_calm - 1;
                    else
                    begin
                        tx_gap <= pick_gap();
                        if ($urandom_range(0, 39) == 0)
                            tx_calm <= 30;
                    end
                end
                else
                    req_ch.valid <= 1'b0;
            end
        end
    end

    // long receiver hold-off so the block backs up into its request side
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_on <= 1'b0;
            hold_left <= 0;
            holds_done <= 0;
        end
        else if (hold_on)
        begin
            if (hold_left <= 1)
                hold_on <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (holds_done < 2 && sent_beats >= (holds_done == 0 ? 40 : 120))
        begin
            hold_on <= 1'b1;
            hold_left <= HOLD_CYCLES;
            holds_done <= holds_done + 1;
        end
    end

    // response monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
            rx_stall <= 0;
            rx_calm <= 0;
        end
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (results_due.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display({"unexpected beat: slot %0d expired %0b status %0b",
                                  " rd %0h last %0b"},
                                 rsp_ch.slot, rsp_ch.expired, rsp_ch.status,
                                 rsp_ch.read_value, rsp_ch.last);
                end
                else
                begin
                    want = results_due.pop_front();
                    if (rsp_ch.slot !== want.slot || rsp_ch.expired !== want.expired ||
                        rsp_ch.status !== want.status ||
                        rsp_ch.read_value !== want.read_value ||
                        rsp_ch.last !== want.last)
                    begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                            $display({"mismatch at %0t: exp slot %0d exp %0b st %0b",
                                      " rd %0h last %0b, got slot %0d exp %0b st %0b",
                                      " rd %0h last %0b"},
                                     $realtime, want.slot, want.expired, want.status,
                                     want.read_value, want.last, rsp_ch.slot,
                                     rsp_ch.expired, rsp_ch.status, rsp_ch.read_value,
                                     rsp_ch.last);
                    end
                end
            end
            if (hold_on)
                rsp_ch.ready <= 1'b0;
            else if (rx_stall > 0)
            begin
                rsp_ch.ready <= 1'b0;
                rx_stall <= rx_stall - 1;
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
                if (rx_calm > 0)
                    rx_calm <= rx_calm - 1;
                else if ($urandom_range(0, 3) == 0)
                    rx_stall <= pick_gap();
                else if ($urandom_range(0, 49) == 0)
                    rx_calm <= 40;
            end
        end
    end

    // watchdog: cycles with no beat on either channel
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idle_cycles <= 0;
            timed_out <= 1'b0;
        end
        else if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT)
            timed_out <= 1'b1;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        int added;
        int r;
        rst_n = 1'b0;
        mismatches = 0;

        // directed: idle tick, reset reads, stop on inactive, zero and full periods,
        // same-deadline ties, one-shot vs periodic, unused action, zero period start
        add_cmd(ACT_TICK, 0, '0, 1'b0);
        add_cmd(ACT_READ, 0, '0, 1'b0);
        add_cmd(ACT_STOP, 3, '0, 1'b0);
        add_cmd(ACT_SETUP, 0, '0, 1'b1);
        add_cmd(ACT_SETUP, 1, 31'd3, 1'b0);
        add_cmd(ACT_SETUP, 2, 31'h7FFF_FFFF, 1'b0);
        add_cmd(ACT_SETUP, 7, 31'd2, 1'b1);
        add_cmd(ACT_READ, 0, 31'h7FFF_FFFF, 1'b1);
        add_cmd(ACT_READ, 2, '0, 1'b0);
        add_cmd(ACT_START, 7, '0, 1'b0);
        add_cmd(ACT_START, 0, '0, 1'b0);
        add_cmd(ACT_START, 1, '0, 1'b0);
        add_cmd(ACT_START, 2, '0, 1'b0);
        add_cmd(ACT_TICK, 0, '0, 1'b0);
        add_cmd(ACT_TICK, 0, '0, 1'b0);
        add_cmd(ACT_TICK, 0, '0, 1'b0);
        add_cmd(ACT_SET_PERIOD, 7, 31'd5, 1'b0);
        add_cmd(ACT_SET_MODE, 1, '0, 1'b1);
        add_cmd(ACT_UNUSED, 5, 31'h5555_5555, 1'b1);
        add_cmd(ACT_STOP, 2, '0, 1'b0);
        add_cmd(ACT_STOP, 2, '0, 1'b0);
        add_cmd(ACT_READ, 7, '0, 1'b0);
        add_cmd(ACT_SETUP, 4, 31'h2AAA_AAAA, 1'b1);
        add_cmd(ACT_START, 6, '0, 1'b0);
        add_cmd(ACT_TICK, 0, '0, 1'b0);

        added = 0;
        while (added < RANDOM_ITEMS)
        begin
            r = $urandom_range(0, 99);
            if (r < 8)
            begin
                // arm every slot with a short period, then tick them all out
                for (int i = 0; i < NUM_TIMERS; i++)
                begin
                    add_cmd(ACT_SETUP, i, VALUE_W'($urandom_range(0, 2)),
                            1'($urandom_range(0, 1)));
                    add_cmd(ACT_START, i, VALUE_W'($urandom), 1'($urandom_range(0, 1)));
                end
                for (int k = 0; k < 3; k++)
                    add_cmd(ACT_TICK, $urandom_range(0, 7), VALUE_W'($urandom),
                            1'($urandom_range(0, 1)));
                added += 2 * NUM_TIMERS + 3;
            end
            else
            begin
                r = $urandom_range(0, 99);
                add_cmd(r < 35 ? ACT_TICK :
                        r < 50 ? ACT_START :
                        r < 62 ? ACT_SETUP :
                        r < 70 ? ACT_STOP :
                        r < 78 ? ACT_SET_PERIOD :
                        r < 86 ? ACT_READ :
                        r < 96 ? ACT_SET_MODE : ACT_UNUSED,
                        $urandom_range(0, 7),
                        $urandom_range(0, 99) < 85 ? VALUE_W'($urandom_range(0, 6))
                                                   : VALUE_W'($urandom),
                        1'($urandom_range(0, 1)));
                added++;
            end
        end

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        while (!timed_out &&
               !(pending_cmds.size() == 0 && !req_ch.valid && results_due.size() == 0))
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (!timed_out && mismatches == 0 && results_due.size() == 0)
            $display("sorted_expiry_timer_bank regression: pass");
        else
            $display("sorted_expiry_timer_bank regression: fail");
        $finish;
    end

endmodule
